@@ hdl/fpjg_pkg.sv @@
// ----------------------------------------------------------------------------
// fpjg_pkg
// Shared widths, register map, control word layout and microprogram for the
// feeder position/speed controller with jam guard.
// ----------------------------------------------------------------------------
package fpjg_pkg;

	// Port field widths
	localparam int SPD_W      = 16;
	localparam int POS_W      = 32;
	localparam int DRV_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Register widths
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 31;
	localparam int SHOT_W  = 20;
	localparam int PER_W   = 16;
	localparam int RT_W    = 16;

	// Internal value widths
	localparam int TGT_W = 40;         // position target
	localparam int EP_W  = TGT_W + 1;  // target minus position
	localparam int ST_W  = 16;         // speed target and clamped drive
	localparam int E_W   = ST_W + 1;   // speed error
	localparam int D_W   = E_W + 1;    // speed error difference
	localparam int INT_W = LIM_W + 1;  // clamped integral

	// Fixed-point fractions
	localparam int FRAC_GAIN = 8;
	localparam int FRAC_I    = 16;

	// Drive clamp
	localparam int DRIVE_LIMIT = 15000;

	// Outer loop decimation default
	localparam int OUTER_DIVIDE_DEF = 2;

	// Shared multiplier: A takes a speed error term, a 24-bit unsigned slice or a signed high part,
	// B a gain or the integration step (up to 20 bits unsigned)
	localparam int MAC_SPLIT = 24;
	localparam int MA_W      = MAC_SPLIT + 1;
	localparam int MB_W      = 21;
	localparam int MP_W      = MA_W + MB_W;
	localparam int ACC_W     = 62;

	localparam int UPC_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_KP       = 3'd0,
		REG_INNER_KD       = 3'd1,
		REG_OUTER_KP       = 3'd2,
		REG_OUTER_KI       = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_SHOT_STEP      = 3'd5,
		REG_TICK_PERIOD    = 3'd6,
		REG_RECOVER_TICKS  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] inner_kp;
		logic [GAIN_W-1:0] inner_kd;
		logic [GAIN_W-1:0] outer_kp;
		logic [GAIN_W-1:0] outer_ki;
		logic [LIM_W-1:0]  integral_limit;
		logic [SHOT_W-1:0] shot_step;
		logic [PER_W-1:0]  tick_period;
		logic [RT_W-1:0]   recover_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		inner_kp:       16'd256,
		inner_kd:       16'd0,
		outer_kp:       16'd256,
		outer_ki:       16'd0,
		integral_limit: 31'd65536,
		shot_step:      20'd8192,
		tick_period:    16'd66,
		recover_ticks:  16'd800
	};

	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_LOAD,
		MAC_ACC
	} mac_op_t;

	typedef enum logic [2:0] {
		A_E,
		A_D,
		A_EP_LO,
		A_EP_HI,
		A_I_LO,
		A_I_HI
	} mac_a_t;

	typedef enum logic [2:0] {
		B_IKP,
		B_IKD,
		B_OKP,
		B_OKI,
		B_DT
	} mac_b_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_ERR,
		DP_DRIVE_FIRE,
		DP_JAM,
		DP_RECOVER,
		DP_EP,
		DP_INTEG,
		DP_IV,
		DP_SPEED
	} dp_op_t;

	typedef enum logic [2:0] {
		J_NONE,
		J_NO_INPUT,
		J_NO_OUTER,
		J_OUT_BUSY,
		J_ALWAYS
	} jmp_t;

	typedef enum logic [UPC_W-1:0] {
		S_IDLE      = 5'd0,
		S_ERR       = 5'd1,
		S_MAC_E     = 5'd2,
		S_MAC_D     = 5'd3,
		S_DRIVE     = 5'd4,
		S_JAM       = 5'd5,
		S_RECOVER   = 5'd6,
		S_EP        = 5'd7,
		S_MAC_DT_LO = 5'd8,
		S_MAC_DT_HI = 5'd9,
		S_INTEG     = 5'd10,
		S_MAC_I_LO  = 5'd11,
		S_MAC_I_HI  = 5'd12,
		S_IV        = 5'd13,
		S_MAC_P_LO  = 5'd14,
		S_MAC_P_HI  = 5'd15,
		S_SPEED     = 5'd16,
		S_EMIT      = 5'd17
	} step_t;

	typedef struct packed {
		mac_op_t mac_op;
		mac_a_t  mac_a;
		mac_b_t  mac_b;
		logic    mac_hi;
		dp_op_t  dp_op;
		jmp_t    jmp;
		step_t   jmp_to;
		logic    emit;
	} ucode_t;

	typedef struct packed {
		logic no_input;
		logic no_outer;
		logic out_busy;
	} cond_t;

	// Microprogram: one control word per step
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucode_t w;
		w = '{mac_op: MAC_NONE, mac_a: A_E, mac_b: B_IKP, mac_hi: 1'b0,
			dp_op: DP_NOP, jmp: J_NONE, jmp_to: S_IDLE, emit: 1'b0};
		case (step_t'(addr))
			S_IDLE: begin
				w.jmp    = J_NO_INPUT;
				w.jmp_to = S_IDLE;
			end
			S_ERR:   w.dp_op = DP_ERR;
			S_MAC_E: begin
				w.mac_op = MAC_LOAD;
				w.mac_a  = A_E;
				w.mac_b  = B_IKP;
			end
			S_MAC_D: begin
				w.mac_op = MAC_ACC;
				w.mac_a  = A_D;
				w.mac_b  = B_IKD;
			end
			S_DRIVE:   w.dp_op = DP_DRIVE_FIRE;
			S_JAM:     w.dp_op = DP_JAM;
			S_RECOVER: begin
				w.dp_op  = DP_RECOVER;
				w.jmp    = J_NO_OUTER;
				w.jmp_to = S_EMIT;
			end
			S_EP: w.dp_op = DP_EP;
			S_MAC_DT_LO: begin
				w.mac_op = MAC_LOAD;
				w.mac_a  = A_EP_LO;
				w.mac_b  = B_DT;
			end
			S_MAC_DT_HI: begin
				w.mac_op = MAC_ACC;
				w.mac_a  = A_EP_HI;
				w.mac_b  = B_DT;
				w.mac_hi = 1'b1;
			end
			S_INTEG: w.dp_op = DP_INTEG;
			S_MAC_I_LO: begin
				w.mac_op = MAC_LOAD;
				w.mac_a  = A_I_LO;
				w.mac_b  = B_OKI;
			end
			S_MAC_I_HI: begin
				w.mac_op = MAC_ACC;
				w.mac_a  = A_I_HI;
				w.mac_b  = B_OKI;
				w.mac_hi = 1'b1;
			end
			S_IV: w.dp_op = DP_IV;
			S_MAC_P_LO: begin
				w.mac_op = MAC_LOAD;
				w.mac_a  = A_EP_LO;
				w.mac_b  = B_OKP;
			end
			S_MAC_P_HI: begin
				w.mac_op = MAC_ACC;
				w.mac_a  = A_EP_HI;
				w.mac_b  = B_OKP;
				w.mac_hi = 1'b1;
			end
			S_SPEED: w.dp_op = DP_SPEED;
			S_EMIT: begin
				w.jmp    = J_OUT_BUSY;
				w.jmp_to = S_EMIT;
				w.emit   = 1'b1;
			end
			default: begin
				w.jmp    = J_ALWAYS;
				w.jmp_to = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hdl/fpjg_seq.sv @@
// ----------------------------------------------------------------------------
// fpjg_seq
// Microsequencer: step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module fpjg_seq
	import fpjg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cond_t  cond,
	output ucode_t ctl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic             taken;

	assign ctl = ucode_rom(upc_q);

	always_comb begin
		case (ctl.jmp)
			J_NONE:     taken = 1'b0;
			J_NO_INPUT: taken = cond.no_input;
			J_NO_OUTER: taken = cond.no_outer;
			J_OUT_BUSY: taken = cond.out_busy;
			J_ALWAYS:   taken = 1'b1;
			default:    taken = 1'b0;
		endcase
	end

	always_comb begin
		if (taken) begin
			upc_nxt = ctl.jmp_to;
		end else if (ctl.emit) begin
			upc_nxt = S_IDLE;
		end else begin
			upc_nxt = upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

@@ hdl/fpjg_mac.sv @@
// ----------------------------------------------------------------------------
// fpjg_mac
// Shared signed multiplier with a wide accumulator; the high slice of a split
// operand is weighted by the slice width.
// ----------------------------------------------------------------------------
module fpjg_mac
	import fpjg_pkg::*;
(
	input  logic                    clk,
	input  mac_op_t                 op,
	input  logic                    hi,
	input  logic signed [MA_W-1:0]  a,
	input  logic signed [MB_W-1:0]  b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [MP_W-1:0]  prod;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = a * b;
	assign term = hi ? (ACC_W'(prod) <<< MAC_SPLIT) : ACC_W'(prod);
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		case (op)
			MAC_LOAD: acc_q <= term;
			MAC_ACC:  acc_q <= acc_q + term;
			default:  acc_q <= acc_q;
		endcase
	end

endmodule

@@ hdl/fpjg_dp.sv @@
// ----------------------------------------------------------------------------
// fpjg_dp
// Datapath: loop state, operand selection for the shared multiplier and the
// per-step updates of speed loop, fire, jam guard, recovery and position loop.
// ----------------------------------------------------------------------------
module fpjg_dp
	import fpjg_pkg::*;
#(
	parameter int OUTER_DIVIDE = OUTER_DIVIDE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ucode_t                  ctl,
	input  cfg_t                    cfg,
	input  logic                    in_take,
	input  logic signed [SPD_W-1:0] speed_feedback,
	input  logic signed [POS_W-1:0] position_feedback,
	input  logic                    fire_request,
	input  logic signed [ACC_W-1:0] acc,
	output logic signed [MA_W-1:0]  opa,
	output logic signed [MB_W-1:0]  opb,
	output logic                    no_outer,
	output logic signed [DRV_W-1:0] drive,
	output logic                    jam
);

	localparam int PH_W = (OUTER_DIVIDE > 1) ? $clog2(OUTER_DIVIDE) : 1;
	localparam int DT_W = PER_W + $clog2(OUTER_DIVIDE);
	localparam logic signed [ACC_W-1:0] DLIM_A = ACC_W'(DRIVE_LIMIT);
	localparam logic signed [ST_W-1:0]  DLIM_S = ST_W'(DRIVE_LIMIT);

	// item registers
	logic signed [SPD_W-1:0] spd_q;
	logic signed [POS_W-1:0] pos_q;
	logic                    fire_q;
	logic signed [E_W-1:0]   e_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [DRV_W-1:0] drive_q;
	logic signed [EP_W-1:0]  ep_q;
	logic signed [INT_W-1:0] iv_q;

	// loop state
	logic signed [TGT_W-1:0] tgt_q;
	logic signed [ST_W-1:0]  speed_q;
	logic signed [E_W-1:0]   prev_q;
	logic signed [INT_W-1:0] integ_q;
	logic                    jam_q;
	logic [RT_W-1:0]         cnt_q;
	logic [PH_W-1:0]         phase_q;

	logic signed [E_W-1:0]   e_nxt;
	logic signed [D_W-1:0]   d_nxt;
	logic signed [ACC_W-1:0] drv_sh;
	logic signed [ACC_W-1:0] drv_neg;
	logic signed [ST_W-1:0]  drv_cl;
	logic signed [TGT_W:0]   fire_sum;
	logic [SHOT_W+2:0]       step6;
	logic [SHOT_W+1:0]       step4;
	logic signed [TGT_W:0]   back_sum;
	logic signed [EP_W-1:0]  lag;
	logic [EP_W-1:0]         lag_mag;
	logic                    jam_hit;
	logic [RT_W:0]           cnt_inc;
	logic                    expire;
	logic [PH_W:0]           phase_inc;
	logic                    due;
	logic [DT_W-1:0]         dt;
	logic signed [ACC_W:0]   int_sum;
	logic signed [ACC_W:0]   lim_w;
	logic signed [INT_W-1:0] lim_i;
	logic signed [INT_W-1:0] integ_nxt;
	logic signed [ACC_W-1:0] spd_sum;
	logic signed [ACC_W-1:0] spd_sh;
	logic signed [ST_W-1:0]  speed_nxt;

	function automatic logic signed [TGT_W-1:0] sat_tgt(input logic signed [TGT_W:0] x);
		if (x[TGT_W] != x[TGT_W-1]) begin
			sat_tgt = x[TGT_W] ? {1'b1, {(TGT_W-1){1'b0}}} : {1'b0, {(TGT_W-1){1'b1}}};
		end else begin
			sat_tgt = x[TGT_W-1:0];
		end
	endfunction

	// speed loop
	always_comb begin
		e_nxt   = E_W'(speed_q) - E_W'(spd_q);
		d_nxt   = D_W'(e_nxt) - D_W'(prev_q);
		drv_sh  = acc >>> FRAC_GAIN;
		drv_neg = -drv_sh;
		if (drv_neg > DLIM_A) begin
			drv_cl = DLIM_S;
		end else if (drv_neg < -DLIM_A) begin
			drv_cl = -DLIM_S;
		end else begin
			drv_cl = drv_neg[ST_W-1:0];
		end
	end

	// fire, jam guard and recovery
	always_comb begin
		step4     = {cfg.shot_step, 2'b00};
		step6     = {cfg.shot_step, 2'b00} + {1'b0, cfg.shot_step, 1'b0};
		fire_sum  = (TGT_W+1)'(tgt_q) + (TGT_W+1)'($signed({1'b0, cfg.shot_step}));
		back_sum  = (TGT_W+1)'(tgt_q) - (TGT_W+1)'($signed({1'b0, step6}));
		lag       = EP_W'(tgt_q) - EP_W'(pos_q);
		lag_mag   = lag[EP_W-1] ? -lag : lag;
		jam_hit   = lag_mag > EP_W'(step4);
		cnt_inc   = {1'b0, cnt_q} + 1'b1;
		expire    = cnt_inc > {1'b0, cfg.recover_ticks};
		phase_inc = {1'b0, phase_q} + 1'b1;
		due       = phase_inc >= (PH_W+1)'(OUTER_DIVIDE);
	end

	// position loop
	always_comb begin
		dt      = DT_W'(cfg.tick_period) * DT_W'(OUTER_DIVIDE);
		int_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(integ_q);
		lim_w   = (ACC_W+1)'($signed({1'b0, cfg.integral_limit}));
		lim_i   = $signed({1'b0, cfg.integral_limit});
		if (int_sum > lim_w) begin
			integ_nxt = lim_i;
		end else if (int_sum < -lim_w) begin
			integ_nxt = -lim_i;
		end else begin
			integ_nxt = int_sum[INT_W-1:0];
		end
		spd_sum = acc + ACC_W'(iv_q);
		spd_sh  = spd_sum >>> FRAC_GAIN;
		if (spd_sh > DLIM_A) begin
			speed_nxt = DLIM_S;
		end else if (spd_sh < -DLIM_A) begin
			speed_nxt = -DLIM_S;
		end else begin
			speed_nxt = spd_sh[ST_W-1:0];
		end
	end

	// multiplier operands; wide values go in as low unsigned and high signed slices
	always_comb begin
		case (ctl.mac_a)
			A_E:     opa = MA_W'(e_q);
			A_D:     opa = MA_W'(d_q);
			A_EP_LO: opa = $signed({1'b0, ep_q[MAC_SPLIT-1:0]});
			A_EP_HI: opa = MA_W'($signed(ep_q[EP_W-1:MAC_SPLIT]));
			A_I_LO:  opa = $signed({1'b0, integ_q[MAC_SPLIT-1:0]});
			A_I_HI:  opa = MA_W'($signed(integ_q[INT_W-1:MAC_SPLIT]));
			default: opa = '0;
		endcase
		case (ctl.mac_b)
			B_IKP:   opb = MB_W'($signed({1'b0, cfg.inner_kp}));
			B_IKD:   opb = MB_W'($signed({1'b0, cfg.inner_kd}));
			B_OKP:   opb = MB_W'($signed({1'b0, cfg.outer_kp}));
			B_OKI:   opb = MB_W'($signed({1'b0, cfg.outer_ki}));
			B_DT:    opb = MB_W'($signed({1'b0, dt}));
			default: opb = '0;
		endcase
	end

	assign no_outer = !due;
	assign drive    = drive_q;
	assign jam      = jam_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			spd_q  <= speed_feedback;
			pos_q  <= position_feedback;
			fire_q <= fire_request;
		end
		case (ctl.dp_op)
			DP_ERR: begin
				e_q <= e_nxt;
				d_q <= d_nxt;
			end
			DP_DRIVE_FIRE: drive_q <= drv_cl[DRV_W-1:0];
			DP_EP:         ep_q    <= lag;
			DP_IV:         iv_q    <= acc[FRAC_I +: INT_W];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= '0;
			speed_q <= '0;
			prev_q  <= '0;
			integ_q <= '0;
			jam_q   <= 1'b0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else begin
			case (ctl.dp_op)
				DP_ERR: prev_q <= e_nxt;
				DP_DRIVE_FIRE: begin
					if (fire_q && !jam_q) begin
						tgt_q <= sat_tgt(fire_sum);
					end
				end
				DP_JAM: begin
					if (jam_hit) begin
						tgt_q <= sat_tgt(back_sum);
						jam_q <= 1'b1;
					end
				end
				DP_RECOVER: begin
					// the tick that raised the flag counts too
					if (jam_q) begin
						if (expire) begin
							jam_q <= 1'b0;
							cnt_q <= '0;
							tgt_q <= TGT_W'(pos_q);
						end else begin
							cnt_q <= cnt_inc[RT_W-1:0];
						end
					end
					phase_q <= due ? '0 : phase_inc[PH_W-1:0];
				end
				DP_INTEG: integ_q <= integ_nxt;
				DP_SPEED: speed_q <= speed_nxt;
				default: begin
				end
			endcase
		end
	end

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!jam_q |-> cnt_q == '0)
		else $error("recovery count running without a jam");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= DLIM_S && speed_q >= -DLIM_S)
		else $error("speed target outside drive limit");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < (PH_W+1)'(OUTER_DIVIDE))
		else $error("outer loop phase out of range");

endmodule

@@ hdl/feeder_position_pid_jam_guard.sv @@
// ----------------------------------------------------------------------------
// feeder_position_pid_jam_guard
// Cascaded position/speed controller for a feeder motor with jam reversal.
//
// One input item is one control tick and gives exactly one result item. The
// tick runs as a microprogram on a single shared 25x21 multiplier, so the
// block takes one item at a time; a tick with a position loop update runs
// extra position loop steps before the result is registered. By default the
// position loop runs on every second tick. The input stalls while a tick is
// in progress; the next item is taken while the previous result still waits
// in the output register, and the sequencer holds on its last step only if
// that register is still occupied and the output is stalled. Registers must
// be written through the cfg port only while no tick is in progress; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module feeder_position_pid_jam_guard
	import fpjg_pkg::*;
#(
	parameter int OUTER_DIVIDE = OUTER_DIVIDE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SPD_W-1:0] speed_feedback,
	input  logic signed [POS_W-1:0] position_feedback,
	input  logic                    fire_request,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [DRV_W-1:0] drive_out,
	output logic                    jam_active,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t                    cfg_q;
	ucode_t                  ctl;
	cond_t                   cond;
	logic                    in_take;
	logic                    no_outer;
	logic                    emit_go;
	logic signed [MA_W-1:0]  opa;
	logic signed [MB_W-1:0]  opb;
	logic signed [ACC_W-1:0] acc;
	logic signed [DRV_W-1:0] drive;
	logic                    jam;
	logic                    out_valid_q;
	logic signed [DRV_W-1:0] drive_out_q;
	logic                    jam_active_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (ctl.jmp != J_NO_INPUT);
	assign in_take   = in_valid && !in_stall;

	always_comb begin
		cond.no_input = !in_valid;
		cond.no_outer = no_outer;
		cond.out_busy = out_valid_q && out_stall;
	end

	assign emit_go = ctl.emit && !cond.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_INNER_KP:       cfg_q.inner_kp       <= cfg_data[GAIN_W-1:0];
				REG_INNER_KD:       cfg_q.inner_kd       <= cfg_data[GAIN_W-1:0];
				REG_OUTER_KP:       cfg_q.outer_kp       <= cfg_data[GAIN_W-1:0];
				REG_OUTER_KI:       cfg_q.outer_ki       <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				REG_SHOT_STEP:      cfg_q.shot_step      <= cfg_data[SHOT_W-1:0];
				REG_TICK_PERIOD:    cfg_q.tick_period    <= cfg_data[PER_W-1:0];
				REG_RECOVER_TICKS:  cfg_q.recover_ticks  <= cfg_data[RT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fpjg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl)
	);

	fpjg_mac u_mac (
		.clk (clk),
		.op  (ctl.mac_op),
		.hi  (ctl.mac_hi),
		.a   (opa),
		.b   (opb),
		.acc (acc)
	);

	fpjg_dp #(
		.OUTER_DIVIDE (OUTER_DIVIDE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.cfg               (cfg_q),
		.in_take           (in_take),
		.speed_feedback    (speed_feedback),
		.position_feedback (position_feedback),
		.fire_request      (fire_request),
		.acc               (acc),
		.opa               (opa),
		.opb               (opb),
		.no_outer          (no_outer),
		.drive             (drive),
		.jam               (jam)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			drive_out_q  <= drive;
			jam_active_q <= jam;
		end
	end

	assign out_valid  = out_valid_q;
	assign drive_out  = drive_out_q;
	assign jam_active = jam_active_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while a tick is in progress");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded while the sequencer was idle");

endmodule
